>>> src/gdce_pkg.sv
// shared types and constants for the gop descriptor cache evictor
package gdce_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int SIZE_W = 24;
  localparam int TIME_W = 32;
  localparam int MAXB_W = 32;
  localparam int MIND_W = 16;
  localparam int CFG_W = 32;
  localparam int CFG_IDX_W = 1;

  localparam int EVC_W = 7;
  localparam int FCNT_W = 7;
  localparam int BTOT_W = 30;
  localparam int KPOS_W = 6;

  localparam logic [MAXB_W-1:0] MAX_BYTES_RST = 32'd4194304;
  localparam logic [MIND_W-1:0] MIN_DUR_RST = 16'd2000;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DUR = 1'd1;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic take;
    logic clr;
    logic head_rd;
    logic full_apply;
    logic push_wr;
    logic fwd_init;
    logic fwd_run;
    logic bwd_init;
    logic bwd_run;
    logic bwd_apply;
    logic drop_apply;
    logic key1;
    logic span_set;
    logic res;
  } ctl_t;

  typedef struct packed {
    logic fwd_done;
    logic bwd_done;
    logic full;
    logic empty;
    logic need;
    logic many_keys;
    logic over;
    logic cfg_kick;
  } sts_t;

endpackage

>>> src/gdce_ram.sv
// generic single-port-write ram with registered read
module gdce_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/gdce_ctrl.sv
// controller state machine sequencing push, clear and eviction passes
module gdce_ctrl import gdce_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic cmd,
  input  sts_t sts,
  output ctl_t ctl,
  output logic busy
);

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_CLR  = 15'b000000000000010,
    S_FRD  = 15'b000000000000100,
    S_FAP  = 15'b000000000001000,
    S_WR   = 15'b000000000010000,
    S_EVS  = 15'b000000000100000,
    S_FWD  = 15'b000000001000000,
    S_CHK  = 15'b000000010000000,
    S_DRD  = 15'b000000100000000,
    S_DAP  = 15'b000001000000000,
    S_BWD  = 15'b000010000000000,
    S_BAP  = 15'b000100000000000,
    S_SPN  = 15'b001000000000000,
    S_SFN  = 15'b010000000000000,
    S_RES  = 15'b100000000000000
  } state_t;

  state_t state, state_next;
  logic quiet, quiet_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      quiet <= 1'b0;
    end else begin
      state <= state_next;
      quiet <= quiet_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    ctl = '0;
    state_next = state;
    quiet_next = quiet;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.take = 1'b1;
          quiet_next = 1'b0;
          if (cmd == CMD_CLEAR) state_next = S_CLR;
          else if (sts.full) state_next = S_FRD;
          else state_next = S_WR;
        end else if (sts.cfg_kick) begin
          // clears the drop counter so the keyframe shift starts from zero
          ctl.take = 1'b1;
          quiet_next = 1'b1;
          state_next = S_EVS;
        end
      end
      S_CLR: begin
        ctl.clr = 1'b1;
        state_next = S_RES;
      end
      S_FRD: begin
        ctl.head_rd = 1'b1;
        state_next = S_FAP;
      end
      S_FAP: begin
        ctl.full_apply = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        ctl.push_wr = 1'b1;
        state_next = S_EVS;
      end
      S_EVS: begin
        ctl.fwd_init = 1'b1;
        state_next = S_FWD;
      end
      S_FWD: begin
        ctl.fwd_run = 1'b1;
        if (sts.fwd_done) state_next = S_CHK;
      end
      S_CHK: begin
        if (!sts.need) begin
          ctl.span_set = 1'b1;
          state_next = quiet ? S_IDLE : S_RES;
        end else if (!sts.many_keys) begin
          state_next = S_DRD;
        end else begin
          ctl.bwd_init = 1'b1;
          state_next = S_BWD;
        end
      end
      S_DRD: begin
        if (!sts.empty && sts.over) begin
          ctl.head_rd = 1'b1;
          state_next = S_DAP;
        end else begin
          ctl.key1 = 1'b1;
          ctl.fwd_init = 1'b1;
          state_next = S_SPN;
        end
      end
      S_DAP: begin
        ctl.drop_apply = 1'b1;
        state_next = S_DRD;
      end
      S_BWD: begin
        ctl.bwd_run = 1'b1;
        if (sts.bwd_done) state_next = S_BAP;
      end
      S_BAP: begin
        ctl.bwd_apply = 1'b1;
        ctl.fwd_init = 1'b1;
        state_next = S_SPN;
      end
      S_SPN: begin
        ctl.fwd_run = 1'b1;
        if (sts.fwd_done) state_next = S_SFN;
      end
      S_SFN: begin
        ctl.span_set = 1'b1;
        state_next = quiet ? S_IDLE : S_RES;
      end
      S_RES: begin
        ctl.res = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> src/gdce_dp.sv
// datapath: descriptor ring, scan accumulators, eviction bookkeeping, result registers
module gdce_dp import gdce_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [SIZE_W-1:0]    frame_bytes,
  input  logic [TIME_W-1:0]    frame_time_ms,
  input  logic                 is_keyframe,
  input  logic                 is_video,
  input  ctl_t                 ctl,
  output sts_t                 sts,
  output logic                 done,
  output logic [EVC_W-1:0]     evicted_count,
  output logic [FCNT_W-1:0]    frame_count,
  output logic [BTOT_W-1:0]    byte_total,
  output logic                 has_keyframe,
  output logic [KPOS_W-1:0]    last_key_position,
  output logic [TIME_W-1:0]    span_ms,
  output logic                 full_drop
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int BW = SIZE_W + CW;
  localparam int XW = (BW > MAXB_W) ? BW : MAXB_W;
  localparam int RW = 1 + TIME_W + SIZE_W;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h, input logic [CW-1:0] p);
    logic [CW:0] s;
    s = (CW + 1)'(h) + (CW + 1)'(p);
    if (s >= (CW + 1)'(DEPTH)) s = s - (CW + 1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  // configuration
  logic [MAXB_W-1:0] max_bytes;
  logic [MIND_W-1:0] min_dur;

  // ring bookkeeping
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [BW-1:0] bytes;
  logic [AW-1:0] key_off;
  logic          key_pres;
  logic [CW-1:0] evicted;
  logic          full;
  logic [TIME_W-1:0] span;

  // latched request
  logic [SIZE_W-1:0] in_size;
  logic [TIME_W-1:0] in_time;
  logic              in_key;

  // scan state
  logic [CW-1:0] pos;
  logic          rd_vld;
  logic [CW-1:0] rd_pos;
  logic [TIME_W-1:0] mn, mx;
  logic [1:0]    nkeys;
  logic [CW-1:0] k0, klast;

  // backward pass state
  logic [BW-1:0]     sb;
  logic [TIME_W-1:0] smin;
  logic              seen;
  logic              tf, ff;
  logic [CW-1:0]     nt_pos, of_pos;
  logic [BW-1:0]     nt_bytes, of_bytes;

  // ram
  logic [AW-1:0] raddr, waddr;
  logic [RW-1:0] rdata, wdata;
  logic [SIZE_W-1:0] r_size;
  logic [TIME_W-1:0] r_time;
  logic              r_key;

  assign {r_key, r_time, r_size} = rdata;
  assign waddr = slot_of(head, count);
  assign wdata = {in_key, in_time, in_size};

  gdce_ram #(.W(RW), .D(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ctl.push_wr),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  logic fwd_issue, bwd_issue;
  logic [CW-1:0] bpos;
  assign fwd_issue = ctl.fwd_run && (pos < count);
  assign bwd_issue = ctl.bwd_run && (pos != '0);
  assign bpos = pos - CW'(1);

  always_comb begin
    if (ctl.head_rd) raddr = head;
    else if (ctl.bwd_run) raddr = slot_of(head, bpos);
    else raddr = slot_of(head, pos);
  end

  // span of the forward scan
  logic [TIME_W-1:0] span_c;
  assign span_c = (mx >= mn) ? (mx - mn) : '0;

  logic over;
  assign over = XW'(bytes) > XW'(max_bytes);

  // single surviving keyframe after front drops
  logic key1_keep;
  assign key1_keep = (nkeys == 2'd1) && (k0 >= evicted);

  assign sts.fwd_done = (pos >= count) && !rd_vld;
  assign sts.bwd_done = (pos == '0) && !rd_vld;
  assign sts.full = (count >= CW'(DEPTH));
  assign sts.empty = (count == '0);
  assign sts.over = over;
  assign sts.need = over || ((TIME_W + 1)'(span_c) > (TIME_W + 1)'({min_dur, 1'b0}));
  assign sts.many_keys = nkeys[1];
  assign sts.cfg_kick = cfg_we && (cfg_index inside {REG_MAX_BYTES, REG_MIN_DUR});

  // backward pass candidate evaluation
  logic [BW-1:0]     sb_n;
  logic [TIME_W-1:0] smin_n;
  logic [TIME_W-1:0] dur;
  logic              fits, cand, taken;
  always_comb begin
    sb_n = sb + BW'(r_size);
    smin_n = (r_time < smin) ? r_time : smin;
    dur = (mx >= smin_n) ? (mx - smin_n) : '0;
    fits = XW'(sb_n) <= XW'(max_bytes);
    cand = r_key && (rd_pos != k0);
    taken = cand && ((dur >= TIME_W'(min_dur)) || (fits && !seen));
  end

  // chosen boundary
  logic [CW-1:0] bnd;
  logic [BW-1:0] bnd_bytes;
  logic [CW:0]   hsum;
  always_comb begin
    if (ff) begin
      bnd = of_pos;
      bnd_bytes = of_bytes;
    end else if (tf) begin
      bnd = nt_pos;
      bnd_bytes = nt_bytes;
    end else begin
      bnd = '0;
      bnd_bytes = bytes;
    end
    hsum = (CW + 1)'(head) + (CW + 1)'(bnd);
    if (hsum >= (CW + 1)'(DEPTH)) hsum = hsum - (CW + 1)'(DEPTH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= MAX_BYTES_RST;
      min_dur <= MIN_DUR_RST;
      head <= '0;
      count <= '0;
      bytes <= '0;
      key_off <= '0;
      key_pres <= 1'b0;
      evicted <= '0;
      full <= 1'b0;
      span <= '0;
      pos <= '0;
      rd_vld <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= ctl.res;
      rd_vld <= fwd_issue || bwd_issue;

      if (cfg_we) begin
        if (cfg_index == REG_MAX_BYTES) max_bytes <= cfg_data;
        else if (cfg_index == REG_MIN_DUR) min_dur <= cfg_data[MIND_W-1:0];
      end

      if (ctl.take) begin
        evicted <= '0;
        full <= 1'b0;
      end

      if (ctl.clr) begin
        head <= '0;
        count <= '0;
        bytes <= '0;
        key_off <= '0;
        key_pres <= 1'b0;
        span <= '0;
      end

      if (ctl.full_apply) begin
        bytes <= bytes - BW'(r_size);
        head <= (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
        count <= count - CW'(1);
        full <= 1'b1;
        if (key_pres) begin
          if (key_off == '0) key_pres <= 1'b0;
          else key_off <= key_off - AW'(1);
        end
      end

      if (ctl.push_wr) begin
        count <= count + CW'(1);
        bytes <= bytes + BW'(in_size);
        if (in_key) begin
          key_off <= AW'(count);
          key_pres <= 1'b1;
        end
      end

      if (ctl.drop_apply) begin
        bytes <= bytes - BW'(r_size);
        head <= (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
        count <= count - CW'(1);
        evicted <= evicted + CW'(1);
      end

      // at most one keyframe held: it just shifts down by the drop count
      if (ctl.key1) begin
        key_pres <= key1_keep;
        key_off <= key1_keep ? AW'(k0 - evicted) : '0;
      end

      if (ctl.bwd_apply) begin
        head <= hsum[AW-1:0];
        count <= count - bnd;
        bytes <= bnd_bytes;
        evicted <= bnd;
        key_pres <= 1'b1;
        key_off <= AW'(klast - bnd);
      end

      if (ctl.span_set) begin
        span <= (count == '0) ? '0 : span_c;
      end

      if (ctl.fwd_init) pos <= '0;
      else if (ctl.bwd_init) pos <= count;
      else if (fwd_issue) pos <= pos + CW'(1);
      else if (bwd_issue) pos <= bpos;
    end
  end

  // payload and scan accumulators
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      in_size <= frame_bytes;
      in_time <= frame_time_ms;
      in_key <= is_keyframe & is_video;
    end

    rd_pos <= ctl.bwd_run ? bpos : pos;

    if (ctl.fwd_init) begin
      mn <= '1;
      mx <= '0;
      nkeys <= '0;
      k0 <= '0;
      klast <= '0;
    end else if (ctl.fwd_run && rd_vld) begin
      if (r_time < mn) mn <= r_time;
      if (r_time > mx) mx <= r_time;
      if (r_key) begin
        if (nkeys == 2'd0) k0 <= rd_pos;
        if (!nkeys[1]) nkeys <= nkeys + 2'd1;
        klast <= rd_pos;
      end
    end

    if (ctl.bwd_init) begin
      sb <= '0;
      smin <= '1;
      seen <= 1'b0;
      tf <= 1'b0;
      ff <= 1'b0;
      nt_pos <= '0;
      of_pos <= '0;
      nt_bytes <= '0;
      of_bytes <= '0;
    end else if (ctl.bwd_run && rd_vld) begin
      sb <= sb_n;
      smin <= smin_n;
      if (cand) seen <= 1'b1;
      // newest taken boundary is the fallback, oldest taken one that fits wins
      if (taken && !tf) begin
        tf <= 1'b1;
        nt_pos <= rd_pos;
        nt_bytes <= sb_n;
      end
      if (taken && fits) begin
        ff <= 1'b1;
        of_pos <= rd_pos;
        of_bytes <= sb_n;
      end
    end

    if (ctl.res) begin
      evicted_count <= EVC_W'(evicted);
      frame_count <= FCNT_W'(count);
      byte_total <= BTOT_W'(bytes);
      has_keyframe <= key_pres;
      last_key_position <= KPOS_W'(key_off);
      span_ms <= span;
      full_drop <= full;
    end
  end

endmodule

>>> src/gop_descriptor_cache_evictor_unit.sv
// gop descriptor cache evictor: top level
// one request at a time; a push raises done after the write, with the oldest frame dropped
// first when the ring is full; an eviction rescans the span, after dropping frames from the
// front when there are fewer than two keyframes or after a backward pass to a keyframe
// boundary otherwise; a clear empties the ring and raises done; a config write made in idle
// without start runs the eviction check with busy high and no result; no stall; rst empties the ring
module gop_descriptor_cache_evictor_unit import gdce_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 cmd,
  input  logic [SIZE_W-1:0]    frame_bytes,
  input  logic [TIME_W-1:0]    frame_time_ms,
  input  logic                 is_keyframe,
  input  logic                 is_video,
  output logic                 done,
  output logic [EVC_W-1:0]     evicted_count,
  output logic [FCNT_W-1:0]    frame_count,
  output logic [BTOT_W-1:0]    byte_total,
  output logic                 has_keyframe,
  output logic [KPOS_W-1:0]    last_key_position,
  output logic [TIME_W-1:0]    span_ms,
  output logic                 full_drop
);

  ctl_t ctl;
  sts_t sts;

  gdce_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  gdce_dp #(.DEPTH(DEPTH)) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .frame_bytes       (frame_bytes),
    .frame_time_ms     (frame_time_ms),
    .is_keyframe       (is_keyframe),
    .is_video          (is_video),
    .ctl               (ctl),
    .sts               (sts),
    .done              (done),
    .evicted_count     (evicted_count),
    .frame_count       (frame_count),
    .byte_total        (byte_total),
    .has_keyframe      (has_keyframe),
    .last_key_position (last_key_position),
    .span_ms           (span_ms),
    .full_drop         (full_drop)
  );

endmodule

>>> bench/gdce_checker.sv
// checker for the gop descriptor cache evictor: predicts each request's result and compares
module gdce_checker import gdce_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 cmd,
  input  logic [SIZE_W-1:0]    frame_bytes,
  input  logic [TIME_W-1:0]    frame_time_ms,
  input  logic                 is_keyframe,
  input  logic                 is_video,
  input  logic                 done,
  input  logic [EVC_W-1:0]     evicted_count,
  input  logic [FCNT_W-1:0]    frame_count,
  input  logic [BTOT_W-1:0]    byte_total,
  input  logic                 has_keyframe,
  input  logic [KPOS_W-1:0]    last_key_position,
  input  logic [TIME_W-1:0]    span_ms,
  input  logic                 full_drop,
  output int                   mismatches,
  output int                   pending,
  output int                   evictions_seen,
  output int                   full_drops_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING = DEPTH_DEF;

  typedef struct packed {
    logic [EVC_W-1:0]  evicted;
    logic [FCNT_W-1:0] count;
    logic [BTOT_W-1:0] bytes;
    logic              key;
    logic [KPOS_W-1:0] kpos;
    logic [TIME_W-1:0] span;
    logic              full;
  } cache_result_t;

  cache_result_t expected_results[$];

  logic [SIZE_W-1:0] ring_size[RING];
  logic [TIME_W-1:0] ring_time[RING];
  logic              ring_key[RING];
  int unsigned       head_pos, held;
  longint unsigned   held_bytes, limit_bytes, min_dur;
  int unsigned       key_pos;
  logic              key_held;
  int unsigned       key_at[RING];

  function automatic int unsigned slot(int unsigned p);
    return (head_pos + p) % RING;
  endfunction

  task automatic drop_oldest();
    held_bytes -= ring_size[head_pos];
    head_pos = (head_pos + 1) % RING;
    held--;
  endtask

  task automatic rescan_key();
    key_held = 0;
    key_pos = 0;
    for (int i = held; i > 0; i--) begin
      if (ring_key[slot(i - 1)]) begin
        key_pos = i - 1;
        key_held = 1;
        break;
      end
    end
  endtask

  task automatic time_bounds(output longint unsigned lo, output longint unsigned hi);
    lo = 64'hFFFF_FFFF;
    hi = 0;
    for (int unsigned i = 0; i < held; i++) begin
      if (ring_time[slot(i)] < lo) lo = ring_time[slot(i)];
      if (ring_time[slot(i)] > hi) hi = ring_time[slot(i)];
    end
  endtask

  task automatic run_eviction(output int unsigned dropped);
    longint unsigned lo, hi, suffix, cmin, dur;
    int unsigned nkeys, boundary, cand;
    dropped = 0;
    nkeys = 0;
    boundary = 0;
    if (held == 0) return;
    time_bounds(lo, hi);
    if (!(held_bytes > limit_bytes || (hi - lo) > 2 * min_dur)) return;
    for (int unsigned i = 0; i < held; i++)
      if (ring_key[slot(i)]) begin
        key_at[nkeys] = i;
        nkeys++;
      end
    if (nkeys < 2) begin
      while (held > 0 && held_bytes > limit_bytes) begin
        drop_oldest();
        dropped++;
      end
      rescan_key();
      return;
    end
    // walk keyframe boundaries oldest first, skipping the first keyframe
    for (int unsigned j = 0; j + 1 < nkeys; j++) begin
      cand = key_at[j + 1];
      suffix = 0;
      cmin = 64'hFFFF_FFFF;
      for (int unsigned i = cand; i < held; i++) begin
        suffix += ring_size[slot(i)];
        if (ring_time[slot(i)] < cmin) cmin = ring_time[slot(i)];
      end
      dur = (hi >= cmin) ? hi - cmin : 0;
      if (dur >= min_dur || (suffix <= limit_bytes && j == nkeys - 2)) begin
        boundary = cand;
        if (suffix <= limit_bytes) break;
      end
    end
    for (int unsigned i = 0; i < boundary; i++) begin
      drop_oldest();
      dropped++;
    end
    rescan_key();
  endtask

  task automatic predict_request();
    cache_result_t r;
    int unsigned ev, s;
    longint unsigned lo, hi;
    r = '0;
    ev = 0;
    if (cmd == CMD_CLEAR) begin
      head_pos = 0;
      held = 0;
      held_bytes = 0;
      key_pos = 0;
      key_held = 0;
    end else begin
      if (held >= RING) begin
        drop_oldest();
        rescan_key();
        r.full = 1'b1;
      end
      s = slot(held);
      ring_size[s] = frame_bytes;
      ring_time[s] = frame_time_ms;
      ring_key[s] = is_keyframe & is_video;
      held++;
      held_bytes += frame_bytes;
      if (ring_key[s]) begin
        key_pos = held - 1;
        key_held = 1;
      end
      run_eviction(ev);
    end
    if (held > 0) begin
      time_bounds(lo, hi);
      r.span = TIME_W'(hi - lo);
    end
    r.evicted = EVC_W'(ev);
    r.count = FCNT_W'(held);
    r.bytes = held_bytes[BTOT_W-1:0];
    r.key = key_held;
    r.kpos = KPOS_W'(key_pos);
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    cache_result_t e;
    int unsigned ev;
    if (rst) begin
      head_pos = 0;
      held = 0;
      held_bytes = 0;
      key_pos = 0;
      key_held = 0;
      limit_bytes = MAX_BYTES_RST;
      min_dur = MIN_DUR_RST;
      expected_results.delete();
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("mismatch at %0t: result with no request outstanding", $time);
          mismatches++;
        end else begin
          e = expected_results[0];
          expected_results.delete(0);
          if (evicted_count != e.evicted) report("evicted_count", evicted_count, e.evicted);
          if (frame_count != e.count) report("frame_count", frame_count, e.count);
          if (byte_total != e.bytes) report("byte_total", byte_total, e.bytes);
          if (has_keyframe != e.key) report("has_keyframe", has_keyframe, e.key);
          if (last_key_position != e.kpos)
            report("last_key_position", last_key_position, e.kpos);
          if (span_ms != e.span) report("span_ms", span_ms, e.span);
          if (full_drop != e.full) report("full_drop", full_drop, e.full);
          if (e.evicted != 0) evictions_seen++;
          if (e.full) full_drops_seen++;
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_MAX_BYTES) limit_bytes = cfg_data;
        else if (cfg_index == REG_MIN_DUR) min_dur = cfg_data[MIND_W-1:0];
        run_eviction(ev);
      end
      if (start && !busy) predict_request();
    end
    pending = expected_results.size();
  end

  initial begin
    mismatches = 0;
    pending = 0;
    evictions_seen = 0;
    full_drops_seen = 0;
  end
endmodule

>>> bench/tb_top.sv
// testbench top for the gop descriptor cache evictor: stimulus, timeout and verdict
module tb_top import gdce_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 3_000_000;

  logic                 clk = 0;
  logic                 rst = 1;
  logic                 start = 0;
  logic                 busy;
  logic                 cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 cmd = CMD_PUSH;
  logic [SIZE_W-1:0]    frame_bytes = '0;
  logic [TIME_W-1:0]    frame_time_ms = '0;
  logic                 is_keyframe = 0;
  logic                 is_video = 0;
  logic                 done;
  logic [EVC_W-1:0]     evicted_count;
  logic [FCNT_W-1:0]    frame_count;
  logic [BTOT_W-1:0]    byte_total;
  logic                 has_keyframe;
  logic [KPOS_W-1:0]    last_key_position;
  logic [TIME_W-1:0]    span_ms;
  logic                 full_drop;

  int     mismatches, pending, evictions_seen, full_drops_seen;
  longint cycles = 0;
  int     requests_sent = 0;
  int     gap_pct = 0;
  logic [TIME_W-1:0] stream_clock = 0;

  always #2 clk = ~clk;

  gop_descriptor_cache_evictor_unit u_top (.*);

  gdce_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // present one request and hold it until accepted
  task automatic send(logic c, logic [SIZE_W-1:0] b, logic [TIME_W-1:0] t, logic k, logic v);
    cmd <= c;
    frame_bytes <= b;
    frame_time_ms <= t;
    is_keyframe <= k;
    is_video <= v;
    start <= 1;
    do @(posedge clk); while (busy);
    requests_sent++;
    if ($urandom_range(99) < gap_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    start <= 0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    repeat (3) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // mostly an ordered stream with keyframes about once per gop_len frames, plus noise and clears
  task automatic random_stream(int n, int size_hi, int step_hi, int gop_len, int clear_pct);
    logic [SIZE_W-1:0] b;
    logic [TIME_W-1:0] t;
    logic k, v;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < clear_pct) begin
        send(CMD_CLEAR, SIZE_W'($urandom), $urandom, 1'($urandom), 1'($urandom));
      end else begin
        r = $urandom_range(99);
        b = (r < 4) ? SIZE_W'($urandom) : (r < 8) ? '0 : SIZE_W'($urandom_range(size_hi));
        r = $urandom_range(99);
        if (r < 4) t = $urandom;
        else begin
          stream_clock += $urandom_range(step_hi);
          t = stream_clock;
        end
        v = $urandom_range(99) < 85;
        k = ($urandom_range(gop_len - 1) == 0) || ($urandom_range(99) < 3);
        send(CMD_PUSH, b, t, k, v);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, clear, audio keyframe, keyframe boundaries, oversize frame
    send(CMD_CLEAR, '1, '1, 1, 1);
    send(CMD_PUSH, '0, '0, 1, 1);
    send(CMD_PUSH, 24'd1000, 32'd10, 1, 0);
    send(CMD_PUSH, 24'd1000, 32'd20, 0, 1);
    send(CMD_PUSH, 24'd1000, 32'd1500, 1, 1);
    send(CMD_PUSH, 24'd1000, 32'd3000, 0, 1);
    send(CMD_PUSH, 24'd1000, 32'd4100, 1, 1);
    send(CMD_PUSH, 24'd1000, 32'd6500, 1, 1);
    send(CMD_PUSH, '1, 32'd6600, 0, 0);
    send(CMD_PUSH, '1, '1, 1, 1);
    send(CMD_PUSH, 24'd5, 32'd0, 0, 1);
    send(CMD_CLEAR, '0, '0, 0, 0);
    send(CMD_PUSH, '1, 32'd100, 0, 1);
    send(CMD_PUSH, 24'd3000000, 32'd200, 1, 1);
    send(CMD_PUSH, 24'd3000000, 32'd300, 1, 1);
    send(CMD_PUSH, 24'd10, '1, 1, 1);
    send(CMD_CLEAR, '0, '0, 0, 0);

    write_reg(REG_MAX_BYTES, '1);
    write_reg(REG_MIN_DUR, 16'hFFFF);
    gap_pct = 0;
    random_stream(160, 4000, 20, 10, 0);
    write_reg(REG_MAX_BYTES, 32'd200000);
    write_reg(REG_MIN_DUR, 16'd100);
    gap_pct = 55;
    random_stream(160, 30000, 40, 6, 2);
    write_reg(REG_MAX_BYTES, '0);
    write_reg(REG_MIN_DUR, '0);
    gap_pct = 9;
    random_stream(120, 2000, 30, 4, 2);
    write_reg(REG_MAX_BYTES, 32'd5000000);
    write_reg(REG_MIN_DUR, 16'd30);
    gap_pct = 0;
    random_stream(160, 400000, 10, 5, 2);
    write_reg(REG_MIN_DUR, 16'd1);
    gap_pct = 30;
    random_stream(160, 100000, 3, 3, 3);
    write_reg(REG_MAX_BYTES, MAX_BYTES_RST);
    write_reg(REG_MIN_DUR, CFG_W'(MIN_DUR_RST));
    gap_pct = 55;
    random_stream(170, 200000, 200, 8, 2);

    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("ran %0d requests over six register settings, idle gaps 0 to 55 percent",
             requests_sent);
    $display("%0d requests evicted frames, %0d forced out the oldest of a full ring",
             evictions_seen, full_drops_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

>>> filelist.f
src/gdce_pkg.sv
src/gdce_ram.sv
src/gdce_ctrl.sv
src/gdce_dp.sv
src/gop_descriptor_cache_evictor_unit.sv
bench/gdce_checker.sv
bench/tb_top.sv
